### hw/rtl/hunk_executable_validator_macros.svh
// Assertion macros shared by the hunk executable validator RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef HUNK_EXECUTABLE_VALIDATOR_MACROS_SVH
`define HUNK_EXECUTABLE_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HEV_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HEV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/hev_pkg.sv
// Package for the hunk executable validator: hunk identifiers, limits and shared types.
// Used by hev_word_asm, hev_parser and hunk_executable_validator; no dependencies.
package hev_pkg;

   localparam int unsigned MAX_HUNKS = 1024;
   localparam logic [31:0] SHORT_FILE_BYTES = 32'd16;
   localparam logic [31:0] POS_LIMIT = 32'hFFFF_FFFF;

   localparam logic [31:0] ID_HEADER  = 32'h0000_03F3;
   localparam logic [31:0] ID_CODE    = 32'h0000_03E9;
   localparam logic [31:0] ID_DATA    = 32'h0000_03EA;
   localparam logic [31:0] ID_BSS     = 32'h0000_03EB;
   localparam logic [31:0] ID_RELOC32 = 32'h0000_03EC;
   localparam logic [31:0] ID_RELOC16 = 32'h0000_03ED;
   localparam logic [31:0] ID_RELOC8  = 32'h0000_03EE;
   localparam logic [31:0] ID_END     = 32'h0000_03F2;

   typedef enum logic [1:0] {
      ST_VALID   = 2'd0,
      ST_INVALID = 2'd1,
      ST_SHORT   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEG_NONE = 2'd0,
      SEG_CODE = 2'd1,
      SEG_DATA = 2'd2,
      SEG_BSS  = 2'd3
   } seg_kind_type;

   typedef enum logic [13:0] {
      PH_MAGIC    = 14'b00_0000_0000_0001,
      PH_NAMELEN  = 14'b00_0000_0000_0010,
      PH_NAMESKIP = 14'b00_0000_0000_0100,
      PH_COUNT    = 14'b00_0000_0000_1000,
      PH_FIRST    = 14'b00_0000_0001_0000,
      PH_LAST     = 14'b00_0000_0010_0000,
      PH_SIZES    = 14'b00_0000_0100_0000,
      PH_SEGWORD  = 14'b00_0000_1000_0000,
      PH_SEGLEN   = 14'b00_0001_0000_0000,
      PH_SEGBODY  = 14'b00_0010_0000_0000,
      PH_RCOUNT   = 14'b00_0100_0000_0000,
      PH_RTARGET  = 14'b00_1000_0000_0000,
      PH_RENTRIES = 14'b01_0000_0000_0000,
      PH_DONE     = 14'b10_0000_0000_0000
   } phase_type;

   typedef struct packed {
      logic        strobe;
      logic [31:0] word;
      logic        huge;
      logic        short_file;
   } word_info_type;

   typedef struct packed {
      status_type  status;
      logic [10:0] num_hunks;
      logic        code_seen;
      logic        data_seen;
      logic        bss_seen;
      logic [31:0] code_total;
      logic [31:0] data_total;
      logic [31:0] bss_total;
      logic [29:0] reloc_blocks;
   } result_type;

endpackage

### hw/rtl/hev_word_asm.sv
// Byte-to-word assembler: builds big-endian 32-bit words and tracks the file length.
// Depends on hev_pkg.
module hev_word_asm
   import hev_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    data_byte,
   input  logic          last_byte,
   output word_info_type word_info
);

   logic [23:0] shift_ff, shift_in;
   logic [1:0]  lane_ff, lane_in;
   logic [31:0] pos_ff, pos_in;

   always_comb begin
      pos_in   = (pos_ff == POS_LIMIT) ? pos_ff : pos_ff + 32'd1;
      lane_in  = lane_ff + 2'd1;
      shift_in = (lane_ff == 2'd3) ? 24'd0 : {shift_ff[15:0], data_byte};
      word_info.strobe     = (lane_ff == 2'd3);
      word_info.word       = {shift_ff, data_byte};
      word_info.huge       = (pos_ff == POS_LIMIT) && !last_byte;
      word_info.short_file = (pos_in < SHORT_FILE_BYTES);
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         shift_ff <= '0;
         lane_ff  <= '0;
         pos_ff   <= '0;
      end else if (step) begin
         shift_ff <= shift_in;
         lane_ff  <= lane_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

### hw/rtl/hev_parser.sv
// Hunk structure parser: phase machine, segment sums and relocation block count.
// Depends on hev_pkg; takes assembled words from hev_word_asm.
module hev_parser
   import hev_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic          last_byte,
   input  word_info_type word_info,
   output result_type    result
);

   phase_type    phase_ff, phase_in;
   logic         verdict_ff, verdict_in;
   logic [31:0]  remain_ff, remain_in;
   logic [10:0]  declared_ff, declared_in;
   logic [31:0]  first_ff, first_in;
   logic [10:0]  done_cnt_ff, done_cnt_in;
   seg_kind_type kind_ff, kind_in;
   logic [2:0]   seen_ff, seen_in;
   logic [31:0]  code_ff, code_in;
   logic [31:0]  data_ff, data_in;
   logic [31:0]  bss_ff, bss_in;
   logic [29:0]  reloc_ff, reloc_in;

   logic [31:0] w;
   logic        run;
   logic        finish;
   logic [32:0] span;
   logic [31:0] cnt_less;
   logic        count_bad;
   logic [31:0] seg_len;
   logic [31:0] seg_sum;
   logic [31:0] seg_add;
   logic        short_file;

   assign w        = word_info.word;
   assign span     = {1'b0, w} - {1'b0, first_ff};
   assign cnt_less = remain_ff - 32'd1;
   assign count_bad = (remain_ff == 32'd0) || span[32] || (span[31:0] != cnt_less)
                      || (remain_ff > 32'(MAX_HUNKS));
   assign seg_len  = (phase_ff == PH_SEGLEN) ? 32'd0 : first_ff;

   always_comb begin
      case (kind_ff)
         SEG_CODE: seg_sum = code_ff;
         SEG_DATA: seg_sum = data_ff;
         default:  seg_sum = bss_ff;
      endcase
   end

   assign seg_add = seg_sum + {seg_len[29:0], 2'b00};

   always_comb begin
      phase_in    = phase_ff;
      verdict_in  = verdict_ff | word_info.huge;
      remain_in   = remain_ff;
      declared_in = declared_ff;
      first_in    = first_ff;
      done_cnt_in = done_cnt_ff;
      kind_in     = kind_ff;
      seen_in     = seen_ff;
      code_in     = code_ff;
      data_in     = data_ff;
      bss_in      = bss_ff;
      reloc_in    = reloc_ff;
      finish      = 1'b0;
      run = word_info.strobe && !verdict_in && (phase_ff != PH_DONE);
      if (run) begin
         case (phase_ff)
            PH_MAGIC: begin
               if (w != ID_HEADER) verdict_in = 1'b1;
               else phase_in = PH_NAMELEN;
            end
            PH_NAMELEN: begin
               if (w == 32'd0) begin
                  phase_in = PH_COUNT;
               end else begin
                  remain_in = w;
                  phase_in  = PH_NAMESKIP;
               end
            end
            PH_NAMESKIP: begin
               remain_in = cnt_less;
               if (remain_ff == 32'd1) phase_in = PH_NAMELEN;
            end
            PH_COUNT: begin
               remain_in = w;
               phase_in  = PH_FIRST;
            end
            PH_FIRST: begin
               first_in = w;
               phase_in = PH_LAST;
            end
            PH_LAST: begin
               if (count_bad) begin
                  verdict_in = 1'b1;
               end else begin
                  declared_in = remain_ff[10:0];
                  phase_in    = PH_SIZES;
               end
            end
            PH_SIZES: begin
               remain_in = cnt_less;
               if (remain_ff == 32'd1) begin
                  done_cnt_in = '0;
                  phase_in    = PH_SEGWORD;
               end
            end
            PH_SEGWORD: begin
               if (w inside {ID_CODE, ID_DATA, ID_BSS}) begin
                  kind_in  = seg_kind_type'(w[1:0]);
                  phase_in = PH_SEGLEN;
               end else if (w inside {ID_RELOC32, ID_RELOC16, ID_RELOC8}) begin
                  phase_in = PH_RCOUNT;
               end else if (w == ID_END) begin
                  done_cnt_in = done_cnt_ff + 11'd1;
                  if (done_cnt_in == declared_ff) phase_in = PH_DONE;
               end else begin
                  verdict_in = 1'b1;
               end
            end
            PH_SEGLEN: begin
               first_in = w;
               if (w == 32'd0) begin
                  finish = 1'b1;
               end else begin
                  remain_in = w;
                  phase_in  = PH_SEGBODY;
               end
            end
            PH_SEGBODY: begin
               remain_in = cnt_less;
               if (remain_ff == 32'd1) finish = 1'b1;
            end
            PH_RCOUNT: begin
               if (w == 32'd0) begin
                  reloc_in = reloc_ff + 30'd1;
                  phase_in = PH_SEGWORD;
               end else begin
                  remain_in = w;
                  phase_in  = PH_RTARGET;
               end
            end
            PH_RTARGET: phase_in = PH_RENTRIES;
            PH_RENTRIES: begin
               remain_in = cnt_less;
               if (remain_ff == 32'd1) phase_in = PH_RCOUNT;
            end
            default: ;
         endcase
      end
      if (finish) begin
         phase_in = PH_SEGWORD;
         case (kind_ff)
            SEG_CODE: begin
               seen_in[0] = 1'b1;
               code_in    = seg_add;
            end
            SEG_DATA: begin
               seen_in[1] = 1'b1;
               data_in    = seg_add;
            end
            default: begin
               seen_in[2] = 1'b1;
               bss_in     = seg_add;
            end
         endcase
      end
   end

   assign short_file = word_info.short_file;

   always_comb begin
      result = '0;
      if (short_file) begin
         result.status = ST_SHORT;
      end else begin
         result.status = (!verdict_in && phase_in == PH_DONE) ? ST_VALID : ST_INVALID;
         if (phase_in inside {PH_SEGWORD, PH_SEGLEN, PH_SEGBODY, PH_RCOUNT, PH_RTARGET,
                              PH_RENTRIES, PH_DONE}) begin
            result.num_hunks = declared_in;
         end
         result.code_seen    = seen_in[0];
         result.data_seen    = seen_in[1];
         result.bss_seen     = seen_in[2];
         result.code_total   = code_in;
         result.data_total   = data_in;
         result.bss_total    = bss_in;
         result.reloc_blocks = reloc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff    <= PH_MAGIC;
         verdict_ff  <= 1'b0;
         remain_ff   <= '0;
         declared_ff <= '0;
         first_ff    <= '0;
         done_cnt_ff <= '0;
         kind_ff     <= SEG_NONE;
         seen_ff     <= '0;
         code_ff     <= '0;
         data_ff     <= '0;
         bss_ff      <= '0;
         reloc_ff    <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         verdict_ff  <= verdict_in;
         remain_ff   <= remain_in;
         declared_ff <= declared_in;
         first_ff    <= first_in;
         done_cnt_ff <= done_cnt_in;
         kind_ff     <= kind_in;
         seen_ff     <= seen_in;
         code_ff     <= code_in;
         data_ff     <= data_in;
         bss_ff      <= bss_in;
         reloc_ff    <= reloc_in;
      end
   end

endmodule

### hw/rtl/hunk_executable_validator.sv
// Hunk executable validator top level: input register, word assembler, parser, result register.
// Depends on hev_pkg, hev_word_asm, hev_parser and hunk_executable_validator_macros.svh.
//
// Usage: the file image enters one byte per item on the req_ channel, with req_tlast
// high on the final byte. Exactly one report item leaves on the rsp_ channel for each
// file, after its last byte. The block sustains one byte per cycle, except while a last
// byte waits for the previous report to be taken; each byte is registered on entry before
// the parser takes it, and the report is registered in the output register when the parser takes the last byte.
// Each byte is a single update of the word assembler and the parse state machine.
// While a report waits in the output register, bytes of the next file keep flowing;
// only a further last byte waits until the report is taken.
// A synchronous reset empties both registers and returns the parser to the header
// check; the parser also returns there by itself after each file.
// Files under 16 bytes report status short with all other fields zero.
`include "hunk_executable_validator_macros.svh"
module hunk_executable_validator
   import hev_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] status, [12:2] num_hunks, [13] code_seen, [14] data_seen, [15] bss_seen,
   // [47:16] code_total, [79:48] data_total, [111:80] bss_total,
   // [141:112] reloc_blocks, [143:142] zero
   output logic [143:0] rsp_tdata
);

   logic          in_vld_ff;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;
   logic          out_vld_ff;
   result_type    out_res_ff;
   logic          advance;
   logic          last_step;
   logic          out_short;
   logic          out_good;
   word_info_type word_info;
   result_type    result;

   assign advance    = in_vld_ff && (!in_last_ff || !out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign last_step  = advance && in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   hev_word_asm u_word_asm (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .word_info (word_info)
   );

   hev_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .last_byte (in_last_ff),
      .word_info (word_info),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (last_step) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (last_step) begin
         out_res_ff <= result;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, out_res_ff.reloc_blocks, out_res_ff.bss_total,
                        out_res_ff.data_total, out_res_ff.code_total, out_res_ff.bss_seen,
                        out_res_ff.data_seen, out_res_ff.code_seen, out_res_ff.num_hunks,
                        out_res_ff.status};

   assign out_short = out_vld_ff && (out_res_ff.status == ST_SHORT);
   assign out_good  = out_vld_ff && (out_res_ff.status == ST_VALID);

   `HEV_ASSERT_IMPL(a_rsp_from_last, $rose(out_vld_ff), $past(last_step), "stray report")
   `HEV_ASSERT_NEXT(a_last_gives_rsp, last_step, out_vld_ff, "last byte lost its report")
   `HEV_ASSERT_IMPL(a_inner_no_stall, in_vld_ff && !in_last_ff, advance, "inner byte stalled")
   `HEV_ASSERT_IMPL(a_short_zero, out_short, rsp_tdata[143:2] == '0, "short report not zero")
   `HEV_ASSERT_IMPL(a_valid_count, out_good, out_res_ff.num_hunks != 11'd0, "zero hunks")

endmodule

### bench/hunk_executable_validator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for hunk_executable_validator: streams hunk file images byte by byte
// and checks every report against a byte-level parser model. Depends on hev_pkg and the RTL.
module hunk_executable_validator_tb;
   import hev_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned HOLD_CYCLES = 400;

   typedef enum logic [3:0] {
      S_MAGIC, S_NAMELEN, S_NAMESKIP, S_COUNT, S_FIRST, S_LAST, S_SIZES,
      S_SEGWORD, S_SEGLEN, S_SEGBODY, S_RCOUNT, S_RTARGET, S_RENTRIES, S_DONE
   } scan_state_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS, RDY_MOSTLY, RDY_HALF, RDY_SPARSE
   } ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;

   scan_state_type scan_state;
   logic [23:0] word_bytes;
   logic [1:0] word_lane;
   logic [31:0] file_offset;
   logic [31:0] count_left;
   logic [10:0] hunks_declared;
   logic [31:0] hunk_first;
   logic [10:0] ends_seen;
   seg_kind_type cur_kind;
   logic [2:0] kinds_seen;
   logic [31:0] exp_code_sum;
   logic [31:0] exp_data_sum;
   logic [31:0] exp_bss_sum;
   logic [29:0] reloc_count;
   logic file_bad;

   result_type pending_reports[$];
   logic [7:0] image[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned burst_left = 0;
   int unsigned hold_request = 0;
   int unsigned hold_taken = 0;
   int unsigned hold_left = 0;
   logic [9:0] rx_cycle = '0;
   ready_mode_type rx_mode;

   hunk_executable_validator dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   task clear_tracker;
      scan_state = S_MAGIC;
      word_bytes = '0;
      word_lane = '0;
      file_offset = '0;
      count_left = '0;
      hunks_declared = '0;
      hunk_first = '0;
      ends_seen = '0;
      cur_kind = SEG_NONE;
      kinds_seen = '0;
      exp_code_sum = '0;
      exp_data_sum = '0;
      exp_bss_sum = '0;
      reloc_count = '0;
      file_bad = 1'b0;
   endtask

   task close_segment;
      logic [31:0] seg_bytes;
      seg_bytes = hunk_first << 2;
      case (cur_kind)
         SEG_CODE: begin
            kinds_seen[0] = 1'b1;
            exp_code_sum = exp_code_sum + seg_bytes;
         end
         SEG_DATA: begin
            kinds_seen[1] = 1'b1;
            exp_data_sum = exp_data_sum + seg_bytes;
         end
         default: begin
            kinds_seen[2] = 1'b1;
            exp_bss_sum = exp_bss_sum + seg_bytes;
         end
      endcase
      scan_state = S_SEGWORD;
   endtask

   task parse_word(input logic [31:0] w);
      case (scan_state)
         S_MAGIC: begin
            if (w != ID_HEADER) file_bad = 1'b1;
            else scan_state = S_NAMELEN;
         end
         S_NAMELEN: begin
            if (w == 0) begin
               scan_state = S_COUNT;
            end else begin
               count_left = w;
               scan_state = S_NAMESKIP;
            end
         end
         S_NAMESKIP: begin
            count_left = count_left - 1;
            if (count_left == 0) scan_state = S_NAMELEN;
         end
         S_COUNT: begin
            count_left = w;
            scan_state = S_FIRST;
         end
         S_FIRST: begin
            hunk_first = w;
            scan_state = S_LAST;
         end
         S_LAST: begin
            if (count_left == 0 || w < hunk_first ||
                  ({1'b0, w - hunk_first} + 33'd1) != {1'b0, count_left} ||
                  count_left > MAX_HUNKS) begin
               file_bad = 1'b1;
            end else begin
               hunks_declared = count_left[10:0];
               scan_state = S_SIZES;
            end
         end
         S_SIZES: begin
            count_left = count_left - 1;
            if (count_left == 0) begin
               ends_seen = '0;
               scan_state = S_SEGWORD;
            end
         end
         S_SEGWORD: begin
            case (w)
               ID_CODE: begin
                  cur_kind = SEG_CODE;
                  scan_state = S_SEGLEN;
               end
               ID_DATA: begin
                  cur_kind = SEG_DATA;
                  scan_state = S_SEGLEN;
               end
               ID_BSS: begin
                  cur_kind = SEG_BSS;
                  scan_state = S_SEGLEN;
               end
               ID_RELOC32, ID_RELOC16, ID_RELOC8: scan_state = S_RCOUNT;
               ID_END: begin
                  ends_seen = ends_seen + 11'd1;
                  if (ends_seen == hunks_declared) scan_state = S_DONE;
               end
               default: file_bad = 1'b1;
            endcase
         end
         S_SEGLEN: begin
            hunk_first = w;
            if (w == 0) begin
               close_segment();
            end else begin
               count_left = w;
               scan_state = S_SEGBODY;
            end
         end
         S_SEGBODY: begin
            count_left = count_left - 1;
            if (count_left == 0) close_segment();
         end
         S_RCOUNT: begin
            if (w == 0) begin
               reloc_count = reloc_count + 30'd1;
               scan_state = S_SEGWORD;
            end else begin
               count_left = w;
               scan_state = S_RTARGET;
            end
         end
         S_RTARGET: scan_state = S_RENTRIES;
         S_RENTRIES: begin
            count_left = count_left - 1;
            if (count_left == 0) scan_state = S_RCOUNT;
         end
         default: ;
      endcase
   endtask

   task track_file_byte(input logic [7:0] b, input logic is_last);
      result_type rep;
      logic [31:0] w;
      if (file_offset == POS_LIMIT) begin
         if (!is_last) file_bad = 1'b1;
      end else begin
         file_offset = file_offset + 1;
      end
      if (word_lane < 3) begin
         word_bytes = {word_bytes[15:0], b};
         word_lane = word_lane + 2'd1;
      end else begin
         w = {word_bytes, b};
         word_bytes = '0;
         word_lane = '0;
         if (!file_bad && scan_state != S_DONE) parse_word(w);
      end
      if (is_last) begin
         rep = '0;
         if (file_offset < SHORT_FILE_BYTES) begin
            rep.status = ST_SHORT;
         end else begin
            rep.status = (!file_bad && scan_state == S_DONE) ? ST_VALID : ST_INVALID;
            rep.num_hunks = (scan_state >= S_SEGWORD) ? hunks_declared : '0;
            rep.code_seen = kinds_seen[0];
            rep.data_seen = kinds_seen[1];
            rep.bss_seen = kinds_seen[2];
            rep.code_total = exp_code_sum;
            rep.data_total = exp_data_sum;
            rep.bss_total = exp_bss_sum;
            rep.reloc_blocks = reloc_count;
         end
         pending_reports.push_back(rep);
         clear_tracker();
      end
   endtask

   task check_report(input logic [143:0] d);
      result_type got;
      result_type want;
      got.status = status_type'(d[1:0]);
      got.num_hunks = d[12:2];
      got.code_seen = d[13];
      got.data_seen = d[14];
      got.bss_seen = d[15];
      got.code_total = d[47:16];
      got.data_total = d[79:48];
      got.bss_total = d[111:80];
      got.reloc_blocks = d[141:112];
      if (pending_reports.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("report with no file behind it: %h", d);
      end else begin
         want = pending_reports.pop_front();
         if (got !== want || d[143:142] !== 2'b00) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("report mismatch: expected status %0d hunks %0d kinds %b%b%b",
                        want.status, want.num_hunks, want.code_seen, want.data_seen,
                        want.bss_seen);
               $display("   sizes %h %h %h relocs %0d", want.code_total, want.data_total,
                        want.bss_total, want.reloc_blocks);
               $display("   actual status %0d hunks %0d kinds %b%b%b pad %b",
                        got.status, got.num_hunks, got.code_seen, got.data_seen,
                        got.bss_seen, d[143:142]);
               $display("   sizes %h %h %h relocs %0d", got.code_total, got.data_total,
                        got.bss_total, got.reloc_blocks);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) track_file_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_report(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      rx_cycle = rx_cycle + 10'd1;
      if (hold_request != hold_taken) begin
         hold_taken = hold_request;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rx_mode = ready_mode_type'(rx_cycle[9:8]);
         case (rx_mode)
            RDY_ALWAYS: rsp_tready <= 1'b1;
            RDY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
            RDY_HALF: rsp_tready <= ($urandom_range(0, 1) == 1);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task send_byte(input logic [7:0] b, input logic is_last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   task send_image;
      int unsigned i;
      for (i = 0; i < image.size(); i++) send_byte(image[i], i == image.size() - 1);
      bytes_sent += image.size();
      image.delete();
   endtask

   task put_word(input logic [31:0] w);
      image.push_back(w[31:24]);
      image.push_back(w[23:16]);
      image.push_back(w[15:8]);
      image.push_back(w[7:0]);
   endtask

   task put_header(input int unsigned n, input logic [31:0] first_id);
      put_word(ID_HEADER);
      put_word(0);
      put_word(n);
      put_word(first_id);
      put_word(first_id + n - 1);
      repeat (n) put_word($urandom);
   endtask

   task drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task build_random_image;
      int unsigned n;
      int unsigned len;
      logic [31:0] first_id;
      image.delete();
      put_word(ID_HEADER);
      repeat ($urandom_range(0, 1)) begin
         len = $urandom_range(1, 3);
         put_word(len);
         repeat (len) put_word($urandom);
      end
      put_word(0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 2);
      first_id = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF - n + 1 : $urandom_range(0, 50);
      put_word(n);
      put_word(first_id);
      put_word(first_id + n - 1);
      repeat (n) put_word($urandom);
      repeat (n) begin
         repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 5))
               0, 1, 2: begin
                  put_word(ID_CODE + $urandom_range(0, 2));
                  len = $urandom_range(0, 4);
                  put_word(len);
                  repeat (len) put_word($urandom);
               end
               default: begin
                  put_word(ID_RELOC32 + $urandom_range(0, 2));
                  repeat ($urandom_range(0, 1)) begin
                     len = $urandom_range(1, 3);
                     put_word(len);
                     put_word($urandom_range(0, 20));
                     repeat (len) put_word($urandom);
                  end
                  put_word(0);
               end
            endcase
         end
         put_word(ID_END);
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 7)) image.push_back(8'($urandom_range(0, 255)));
   endtask

   task test_short_files;
      image.push_back(8'h00);
      send_image();
      repeat (15) image.push_back(8'hFF);
      send_image();
      put_word(ID_HEADER);
      put_word(0);
      put_word(1);
      repeat (3) image.push_back(8'h00);
      send_image();
      put_word(ID_HEADER);
      put_word(0);
      put_word(1);
      put_word(0);
      send_image();
   endtask

   task test_valid_layouts;
      put_header(1, 0);
      put_word(ID_CODE);
      put_word(0);
      put_word(ID_END);
      send_image();

      put_word(ID_HEADER);
      put_word(1);
      put_word($urandom);
      put_word(3);
      put_word(32'hFFFF_FFFF);
      put_word(0);
      put_word(ID_END);
      put_word(0);
      put_word(3);
      put_word(5);
      put_word(7);
      repeat (3) put_word($urandom);
      put_word(ID_CODE);
      put_word(2);
      put_word(32'hFFFF_FFFF);
      put_word(32'h0000_0000);
      put_word(ID_RELOC32);
      put_word(0);
      put_word(ID_END);
      put_word(ID_DATA);
      put_word(1);
      put_word($urandom);
      put_word(ID_RELOC16);
      put_word(2);
      put_word(0);
      put_word($urandom);
      put_word($urandom);
      put_word(1);
      put_word(1);
      put_word($urandom);
      put_word(0);
      put_word(ID_END);
      put_word(ID_BSS);
      put_word(3);
      repeat (3) put_word($urandom);
      put_word(ID_RELOC8);
      put_word(0);
      put_word(ID_END);
      image.push_back(8'hA5);
      repeat (4) image.push_back(8'($urandom_range(0, 255)));
      send_image();

      put_header(2, 32'hFFFF_FFFE);
      put_word(ID_BSS);
      put_word(0);
      put_word(ID_END);
      put_word(ID_END);
      send_image();
   endtask

   task test_header_errors;
      put_word(ID_HEADER + 1);
      repeat (4) put_word(0);
      send_image();
      put_word(ID_HEADER);
      repeat (4) put_word(0);
      send_image();
      put_word(ID_HEADER);
      put_word(0);
      put_word(1);
      put_word(5);
      put_word(4);
      send_image();
      put_word(ID_HEADER);
      put_word(0);
      put_word(2);
      put_word(0);
      put_word(2);
      put_word(0);
      send_image();
      put_word(ID_HEADER);
      put_word(0);
      put_word(MAX_HUNKS + 1);
      put_word(0);
      put_word(MAX_HUNKS);
      put_word(0);
      send_image();
      put_word(ID_HEADER);
      put_word(0);
      put_word(1);
      put_word(0);
      put_word(32'hFFFF_FFFF);
      put_word(0);
      send_image();
   endtask

   task test_format_errors;
      put_header(1, 0);
      put_word(ID_HEADER - 4);
      send_image();
      put_header(1, 0);
      put_word(ID_CODE);
      put_word(4);
      repeat (2) put_word($urandom);
      send_image();
      put_header(1, 0);
      put_word(ID_CODE);
      put_word(0);
      put_word(ID_RELOC32);
      put_word(3);
      put_word(0);
      put_word($urandom);
      send_image();
      put_header(1, 0);
      put_word(ID_CODE);
      put_word(0);
      image.push_back(8'h03);
      image.push_back(8'hF2);
      send_image();
      put_word(ID_HEADER);
      put_word(0);
      put_word(3);
      put_word(0);
      put_word(2);
      put_word($urandom);
      send_image();
      put_word(ID_HEADER);
      put_word(5);
      repeat (3) put_word($urandom);
      send_image();
      put_header(2, 0);
      put_word(ID_CODE);
      put_word(1);
      put_word($urandom);
      put_word(ID_END + 1);
      put_word(ID_DATA);
      put_word(0);
      put_word(ID_END);
      put_word(ID_END);
      send_image();
   endtask

   task test_backpressure;
      hold_request <= hold_request + 1;
      repeat (2) begin
         build_random_image();
         send_image();
      end
      drain();
   endtask

   task test_random_files;
      int unsigned files;
      int unsigned cut;
      files = 0;
      while (bytes_sent < 900 || files < 2) begin
         build_random_image();
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  cut = $urandom_range(1, image.size() - 1);
                  while (image.size() > cut) image.delete(image.size() - 1);
               end
               1: repeat ($urandom_range(1, 3))
                     image[$urandom_range(0, image.size() - 1)] = 8'($urandom_range(0, 255));
               default: begin
                  image.delete();
                  if ($urandom_range(0, 1)) put_word(ID_HEADER);
                  repeat ($urandom_range(1, 40)) image.push_back(8'($urandom_range(0, 255)));
               end
            endcase
         end
         send_image();
         files++;
      end
   endtask

   initial begin
      clear_tracker();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_short_files();
      test_valid_layouts();
      drain();
      test_header_errors();
      test_format_errors();
      drain();
      test_backpressure();
      test_random_files();
      drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/hev_pkg.sv
hw/rtl/hev_word_asm.sv
hw/rtl/hev_parser.sv
hw/rtl/hunk_executable_validator.sv
bench/hunk_executable_validator_tb.sv
